// File: hw/rtl/qrv_pkg.sv
package qrv_pkg;

   localparam int QUAT_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_QUAT_X = 2'd0,
      REG_QUAT_Y = 2'd1,
      REG_QUAT_Z = 2'd2,
      REG_QUAT_W = 2'd3
   } csr_index_type;

   // exact width of q x v plus rounding offset
   function automatic int full_width(input int cw, input int fb);
      int w;
      begin
         w = (cw + 17 > fb + 1) ? cw + 17 : fb + 1;
         return w + 1;
      end
   endfunction

   // width of the rounded first cross product
   function automatic int uv_width(input int cw, input int fb);
      int w;
      begin
         w = full_width(cw, fb) - fb;
         return (w > 2) ? w : 2;
      end
   endfunction

   // scalar register must hold 1.0 at any fraction width
   function automatic int quat_w_width(input int fb);
      return (fb + 2 > QUAT_WIDTH) ? fb + 2 : QUAT_WIDTH;
   endfunction

   // 2*w*uv + 2*(q x uv) plus rounding offset
   function automatic int acc_width(input int cw, input int fb);
      int mw;
      begin
         mw = quat_w_width(fb) + uv_width(cw, fb);
         return ((mw + 3 > fb + 1) ? mw + 3 : fb + 1) + 1;
      end
   endfunction

   // rounded accumulator, wide enough to add v without overflow
   function automatic int racc_width(input int cw, input int fb);
      int w;
      begin
         w = acc_width(cw, fb) - fb;
         return ((w > cw) ? w : cw) + 1;
      end
   endfunction

endpackage

// File: hw/rtl/qrv_uv.sv
module qrv_uv #(
   parameter int COORD_WIDTH    = 16,
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic signed [COORD_WIDTH-1:0]            vec [3],
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0]    quat_x,
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0]    quat_y,
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0]    quat_z,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic signed [COORD_WIDTH-1:0]            out_vec [3],
   output logic signed [qrv_pkg::uv_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] out_uv [3]
);

   localparam int QW = qrv_pkg::QUAT_WIDTH;
   localparam int PW = QW + COORD_WIDTH;
   localparam int FW = qrv_pkg::full_width(COORD_WIDTH, QUAT_FRAC_BITS);
   localparam int UW = qrv_pkg::uv_width(COORD_WIDTH, QUAT_FRAC_BITS);
   localparam logic signed [FW-1:0] HALF = FW'(1) << (QUAT_FRAC_BITS - 1);

   logic signed [QW-1:0]          qv [3];
   logic signed [PW-1:0]          pos_in [3];
   logic signed [PW-1:0]          neg_in [3];
   logic signed [PW-1:0]          pos_ff [3];
   logic signed [PW-1:0]          neg_ff [3];
   logic signed [FW-1:0]          full_sum [3];
   logic signed [UW-1:0]          uv_in [3];
   logic signed [UW-1:0]          uv_ff [3];
   logic signed [COORD_WIDTH-1:0] vec_a_ff [3];
   logic signed [COORD_WIDTH-1:0] vec_b_ff [3];
   logic                          valid_a_ff;
   logic                          valid_b_ff;
   logic                          ready_a;
   logic                          ready_b;

   assign qv[0] = quat_x;
   assign qv[1] = quat_y;
   assign qv[2] = quat_z;

   for (genvar i = 0; i < 3; i++) begin : g_comp
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      assign pos_in[i]   = PW'(qv[J]) * PW'(vec[K]);
      assign neg_in[i]   = PW'(qv[K]) * PW'(vec[J]);
      assign full_sum[i] = FW'(pos_ff[i]) - FW'(neg_ff[i]) + HALF;
      assign uv_in[i]    = UW'(full_sum[i] >>> QUAT_FRAC_BITS);
   end

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            valid_a_ff <= in_valid;
         end
         if (ready_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         vec_a_ff <= vec;
      end
      if (ready_b) begin
         uv_ff    <= uv_in;
         vec_b_ff <= vec_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_vec   = vec_b_ff;
   assign out_uv    = uv_ff;

endmodule

// File: hw/rtl/qrv_uuv.sv
module qrv_uuv #(
   parameter int COORD_WIDTH    = 16,
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic signed [COORD_WIDTH-1:0]            vec [3],
   input  logic signed [qrv_pkg::uv_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] uv [3],
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0]    quat_x,
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0]    quat_y,
   input  logic signed [qrv_pkg::QUAT_WIDTH-1:0]    quat_z,
   input  logic signed [qrv_pkg::quat_w_width(QUAT_FRAC_BITS)-1:0] quat_w,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic signed [COORD_WIDTH-1:0]            out_vec [3],
   output logic signed [qrv_pkg::racc_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] out_racc [3]
);

   localparam int QW = qrv_pkg::QUAT_WIDTH;
   localparam int WW = qrv_pkg::quat_w_width(QUAT_FRAC_BITS);
   localparam int UW = qrv_pkg::uv_width(COORD_WIDTH, QUAT_FRAC_BITS);
   localparam int PW = QW + UW;
   localparam int MW = WW + UW;
   localparam int AW = qrv_pkg::acc_width(COORD_WIDTH, QUAT_FRAC_BITS);
   localparam int RW = qrv_pkg::racc_width(COORD_WIDTH, QUAT_FRAC_BITS);
   localparam logic signed [AW-1:0] HALF = AW'(1) << (QUAT_FRAC_BITS - 1);

   logic signed [QW-1:0]          qv [3];
   logic signed [PW-1:0]          pos_in [3];
   logic signed [PW-1:0]          neg_in [3];
   logic signed [MW-1:0]          wuv_in [3];
   logic signed [PW-1:0]          pos_ff [3];
   logic signed [PW-1:0]          neg_ff [3];
   logic signed [MW-1:0]          wuv_ff [3];
   logic signed [AW-1:0]          acc [3];
   logic signed [RW-1:0]          racc_in [3];
   logic signed [RW-1:0]          racc_ff [3];
   logic signed [COORD_WIDTH-1:0] vec_a_ff [3];
   logic signed [COORD_WIDTH-1:0] vec_b_ff [3];
   logic                          valid_a_ff;
   logic                          valid_b_ff;
   logic                          ready_a;
   logic                          ready_b;

   assign qv[0] = quat_x;
   assign qv[1] = quat_y;
   assign qv[2] = quat_z;

   for (genvar i = 0; i < 3; i++) begin : g_comp
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      assign pos_in[i]  = PW'(qv[J]) * PW'(uv[K]);
      assign neg_in[i]  = PW'(qv[K]) * PW'(uv[J]);
      assign wuv_in[i]  = MW'(quat_w) * MW'(uv[i]);
      assign acc[i]     = ((AW'(wuv_ff[i]) + AW'(pos_ff[i]) - AW'(neg_ff[i])) <<< 1) + HALF;
      assign racc_in[i] = RW'(acc[i] >>> QUAT_FRAC_BITS);
   end

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            valid_a_ff <= in_valid;
         end
         if (ready_b) begin
            valid_b_ff <= valid_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         wuv_ff   <= wuv_in;
         vec_a_ff <= vec;
      end
      if (ready_b) begin
         racc_ff  <= racc_in;
         vec_b_ff <= vec_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_vec   = vec_b_ff;
   assign out_racc  = racc_ff;

endmodule

// File: hw/rtl/qrv_sat.sv
module qrv_sat #(
   parameter int COORD_WIDTH    = 16,
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic signed [COORD_WIDTH-1:0]            vec [3],
   input  logic signed [qrv_pkg::racc_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] racc [3],
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic signed [COORD_WIDTH-1:0]            out_rot [3],
   output logic                                     out_clipped
);

   localparam int RW = qrv_pkg::racc_width(COORD_WIDTH, QUAT_FRAC_BITS);
   localparam int HW = RW - COORD_WIDTH + 1;

   logic signed [RW-1:0]          sum [3];
   logic [HW-1:0]                 top_bits [3];
   logic [2:0]                    over;
   logic signed [COORD_WIDTH-1:0] rot_in [3];
   logic signed [COORD_WIDTH-1:0] rot_ff [3];
   logic                          clipped_ff;
   logic                          valid_ff;
   logic                          ready;

   for (genvar i = 0; i < 3; i++) begin : g_comp
      assign sum[i]      = RW'(vec[i]) + racc[i];
      assign top_bits[i] = sum[i][RW-1:COORD_WIDTH-1];
      // fits when all bits above the sign agree with it
      assign over[i]     = !((&top_bits[i]) || !(|top_bits[i]));
      always_comb begin
         if (!over[i]) begin
            rot_in[i] = sum[i][COORD_WIDTH-1:0];
         end else if (sum[i][RW-1]) begin
            rot_in[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         end else begin
            rot_in[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end
      end
   end

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         rot_ff     <= rot_in;
         clipped_ff <= |over;
      end
   end

   assign out_valid   = valid_ff;
   assign out_rot     = rot_ff;
   assign out_clipped = clipped_ff;

endmodule

// File: hw/rtl/quaternion_rotate_vector_top.sv
// Rotates one 3D vector per clock by the quaternion held in csr registers
// quat_x/y/z/w (Q1.14, reset to identity), as v + 2w(q x v) + 2(q x (q x v)).
// Coordinates are signed Q8.8; each result coordinate saturates and rsp_tuser
// flags the beat if any did. Throughput is one beat per cycle when the output is
// not held off; each beat passes through the multiply/round stages of the two
// cross products and the final add-and-saturate output register. Backpressure
// stalls each stage only when it holds data, so empty stages keep filling. Write
// the quaternion only while no beat is in flight.
module quaternion_rotate_vector_top #(
   parameter int COORD_WIDTH    = 16,
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // vec_x, vec_y, vec_z
   input  logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // rot_x, rot_y, rot_z
   output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // clipped
   output logic                                        rsp_tuser,
   input  logic                                        csr_we,
   input  logic [qrv_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [qrv_pkg::QUAT_WIDTH-1:0]              csr_wdata
);

   localparam int DW = ((3 * COORD_WIDTH + 7) / 8) * 8;
   localparam int QW = qrv_pkg::QUAT_WIDTH;
   localparam int WW = qrv_pkg::quat_w_width(QUAT_FRAC_BITS);
   localparam int UW = qrv_pkg::uv_width(COORD_WIDTH, QUAT_FRAC_BITS);
   localparam int RW = qrv_pkg::racc_width(COORD_WIDTH, QUAT_FRAC_BITS);

   logic signed [QW-1:0]          quat_x_ff;
   logic signed [QW-1:0]          quat_y_ff;
   logic signed [QW-1:0]          quat_z_ff;
   logic signed [WW-1:0]          quat_w_ff;

   logic signed [COORD_WIDTH-1:0] vec [3];
   logic signed [COORD_WIDTH-1:0] vec_1 [3];
   logic signed [COORD_WIDTH-1:0] vec_2 [3];
   logic signed [UW-1:0]          uv [3];
   logic signed [RW-1:0]          racc [3];
   logic signed [COORD_WIDTH-1:0] rot [3];
   logic                          valid_1;
   logic                          ready_1;
   logic                          valid_2;
   logic                          ready_2;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
         quat_w_ff <= WW'(1) << QUAT_FRAC_BITS;
      end else if (csr_we) begin
         case (qrv_pkg::csr_index_type'(csr_index))
            qrv_pkg::REG_QUAT_X: quat_x_ff <= csr_wdata;
            qrv_pkg::REG_QUAT_Y: quat_y_ff <= csr_wdata;
            qrv_pkg::REG_QUAT_Z: quat_z_ff <= csr_wdata;
            qrv_pkg::REG_QUAT_W: quat_w_ff <= WW'($signed(csr_wdata));
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign vec[i] = req_tdata[i * COORD_WIDTH +: COORD_WIDTH];
   end

   qrv_uv #(
      .COORD_WIDTH    (COORD_WIDTH),
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_uv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .vec       (vec),
      .quat_x    (quat_x_ff),
      .quat_y    (quat_y_ff),
      .quat_z    (quat_z_ff),
      .out_valid (valid_1),
      .out_ready (ready_1),
      .out_vec   (vec_1),
      .out_uv    (uv)
   );

   qrv_uuv #(
      .COORD_WIDTH    (COORD_WIDTH),
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_uuv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_1),
      .in_ready  (ready_1),
      .vec       (vec_1),
      .uv        (uv),
      .quat_x    (quat_x_ff),
      .quat_y    (quat_y_ff),
      .quat_z    (quat_z_ff),
      .quat_w    (quat_w_ff),
      .out_valid (valid_2),
      .out_ready (ready_2),
      .out_vec   (vec_2),
      .out_racc  (racc)
   );

   qrv_sat #(
      .COORD_WIDTH    (COORD_WIDTH),
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_sat (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (valid_2),
      .in_ready    (ready_2),
      .vec         (vec_2),
      .racc        (racc),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_rot     (rot),
      .out_clipped (rsp_tuser)
   );

   assign rsp_tdata = DW'({rot[2], rot[1], rot[0]});

endmodule

// File: test/quaternion_rotate_vector_top_tb.sv
module quaternion_rotate_vector_top_tb;

   localparam int COORD_W   = 16;
   localparam int FRAC_BITS = 14;
   localparam int DATA_W    = ((3 * COORD_W + 7) / 8) * 8;
   localparam longint ROUND_HALF = longint'(1) <<< (FRAC_BITS - 1);
   localparam longint COORD_MAX  = 32767;
   localparam longint COORD_MIN  = -32768;
   localparam int RAND_PHASES  = 6;
   localparam int PHASE_BEATS  = 150;
   localparam int CYCLE_LIMIT  = 300000;

   typedef longint vec3_type [3];

   typedef struct packed {
      logic [15:0] rx;
      logic [15:0] ry;
      logic [15:0] rz;
      logic        clip;
   } rot_beat_type;

   typedef enum logic [1:0] {
      ROW_QUAT,
      ROW_VEC,
      ROW_VEC_KNOWN
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  a;
      logic [15:0]  b;
      logic [15:0]  c;
      logic [15:0]  d;
      rot_beat_type known;
   } stim_row_type;

   localparam rot_beat_type NO_ROT = '0;

   // quat rows: a..d = x, y, z, w; vector rows: a..c = x, y, z
   localparam stim_row_type DIR_TBL [26] = '{
      '{ROW_VEC_KNOWN, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        '{16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{ROW_VEC_KNOWN, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000,
        '{16'h7fff, 16'h7fff, 16'h7fff, 1'b0}},
      '{ROW_VEC_KNOWN, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
        '{16'h8000, 16'h8000, 16'h8000, 1'b0}},
      '{ROW_VEC_KNOWN, 16'h0001, 16'hffff, 16'h0100, 16'h0000,
        '{16'h0001, 16'hffff, 16'h0100, 1'b0}},
      '{ROW_VEC_KNOWN, 16'h7fff, 16'h8000, 16'h5555, 16'h0000,
        '{16'h7fff, 16'h8000, 16'h5555, 1'b0}},
      // half turn about x: (x, y, z) -> (x, -y, -z)
      '{ROW_QUAT, 16'h4000, 16'h0000, 16'h0000, 16'h0000, NO_ROT},
      '{ROW_VEC_KNOWN, 16'h0064, 16'h00c8, 16'hfed4, 16'h0000,
        '{16'h0064, 16'hff38, 16'h012c, 1'b0}},
      '{ROW_VEC_KNOWN, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
        '{16'h8000, 16'h7fff, 16'h7fff, 1'b1}},
      '{ROW_VEC_KNOWN, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000,
        '{16'h7fff, 16'h8001, 16'h8001, 1'b0}},
      '{ROW_QUAT, 16'h8000, 16'h0000, 16'h0000, 16'h0000, NO_ROT},
      '{ROW_VEC, 16'h0100, 16'h0200, 16'h0300, 16'h0000, NO_ROT},
      '{ROW_VEC, 16'h7fff, 16'h8000, 16'h1234, 16'h0000, NO_ROT},
      '{ROW_QUAT, 16'h0000, 16'h0000, 16'h0000, 16'h8000, NO_ROT},
      '{ROW_VEC, 16'h1234, 16'h8000, 16'h7fff, 16'h0000, NO_ROT},
      '{ROW_QUAT, 16'h8000, 16'h8000, 16'h8000, 16'h8000, NO_ROT},
      '{ROW_VEC, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, NO_ROT},
      '{ROW_VEC, 16'h0001, 16'h0000, 16'hffff, 16'h0000, NO_ROT},
      '{ROW_QUAT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, NO_ROT},
      '{ROW_VEC, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, NO_ROT},
      '{ROW_VEC, 16'h00ff, 16'hff00, 16'h0f0f, 16'h0000, NO_ROT},
      // quarter turns about z, then y
      '{ROW_QUAT, 16'h0000, 16'h0000, 16'h2d41, 16'h2d41, NO_ROT},
      '{ROW_VEC, 16'h0100, 16'h0000, 16'h0000, 16'h0000, NO_ROT},
      '{ROW_VEC, 16'h0000, 16'h0100, 16'h0000, 16'h0000, NO_ROT},
      '{ROW_VEC, 16'haaaa, 16'h5555, 16'h0000, 16'h0000, NO_ROT},
      '{ROW_QUAT, 16'h0000, 16'h2d41, 16'h0000, 16'h2d41, NO_ROT},
      '{ROW_VEC, 16'h0100, 16'h0200, 16'h0300, 16'h0000, NO_ROT}
   };

   localparam logic [15:0] QUAT_EDGES [5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000,
                                              16'hc000};

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tuser;
   logic              csr_we;
   logic [qrv_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [qrv_pkg::QUAT_WIDTH-1:0]      csr_wdata;

   logic [15:0]  quat_reg [4] = '{16'h0000, 16'h0000, 16'h0000, 16'h4000};
   rot_beat_type expected_rot_q [$];
   string        field_name [4] = '{"rot_x", "rot_y", "rot_z", "clipped"};
   int           err_cnt = 0;
   int           cycle_cnt = 0;
   bit           tx_gappy;

   quaternion_rotate_vector_top #(
      .COORD_WIDTH    (COORD_W),
      .QUAT_FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic vec3_type cross3(input vec3_type a, input vec3_type b);
      vec3_type r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   // round half up at the quaternion fraction width
   function automatic longint round_q(input longint y);
      return (y + ROUND_HALF) >>> FRAC_BITS;
   endfunction

   function automatic rot_beat_type rotate_vec(input logic [15:0] vx, input logic [15:0] vy,
                                               input logic [15:0] vz);
      vec3_type     v;
      vec3_type     qv;
      vec3_type     uv;
      vec3_type     uuv;
      longint       qw;
      longint       r;
      logic [15:0]  outc [3];
      rot_beat_type res;
      v[0]  = $signed(vx);
      v[1]  = $signed(vy);
      v[2]  = $signed(vz);
      qv[0] = $signed(quat_reg[qrv_pkg::REG_QUAT_X]);
      qv[1] = $signed(quat_reg[qrv_pkg::REG_QUAT_Y]);
      qv[2] = $signed(quat_reg[qrv_pkg::REG_QUAT_Z]);
      qw    = $signed(quat_reg[qrv_pkg::REG_QUAT_W]);
      uv = cross3(qv, v);
      for (int i = 0; i < 3; i++) uv[i] = round_q(uv[i]);
      uuv = cross3(qv, uv);
      res.clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
         r = v[i] + round_q(2 * qw * uv[i] + 2 * uuv[i]);
         if (r > COORD_MAX) begin
            r = COORD_MAX;
            res.clip = 1'b1;
         end else if (r < COORD_MIN) begin
            r = COORD_MIN;
            res.clip = 1'b1;
         end
         outc[i] = r[15:0];
      end
      res.rx = outc[0];
      res.ry = outc[1];
      res.rz = outc[2];
      return res;
   endfunction

   task automatic send_vec(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                           input bit typed, input rot_beat_type typed_rot);
      int gap;
      gap = tx_gappy ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
      expected_rot_q.push_back(typed ? typed_rot : rotate_vec(x, y, z));
   endtask

   // drain the pipe, then write all four quaternion registers
   task automatic load_quat(input logic [15:0] qx, input logic [15:0] qy,
                            input logic [15:0] qz, input logic [15:0] qw);
      logic [15:0] vals [4];
      vals = '{qx, qy, qz, qw};
      req_tvalid <= 1'b0;
      while (expected_rot_q.size() != 0) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= qrv_pkg::csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         quat_reg[i] = vals[i];
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [15:0] qn [4];
      logic [15:0] vn [3];
      int          mode;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= qrv_pkg::REG_QUAT_X;
      csr_wdata  <= '0;
      tx_gappy   = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TBL[i]) begin
         case (DIR_TBL[i].kind)
            ROW_QUAT: begin
               load_quat(DIR_TBL[i].a, DIR_TBL[i].b, DIR_TBL[i].c, DIR_TBL[i].d);
            end
            ROW_VEC_KNOWN: begin
               send_vec(DIR_TBL[i].a, DIR_TBL[i].b, DIR_TBL[i].c, 1'b1, DIR_TBL[i].known);
            end
            default: begin
               send_vec(DIR_TBL[i].a, DIR_TBL[i].b, DIR_TBL[i].c, 1'b0, NO_ROT);
            end
         endcase
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         mode = $urandom_range(0, 2);
         for (int k = 0; k < 4; k++) begin
            case (mode)
               0: qn[k] = $urandom;
               1: qn[k] = 16'($urandom_range(0, 23170)) - 16'd11585;
               default: qn[k] = QUAT_EDGES[$urandom_range(0, 4)];
            endcase
         end
         load_quat(qn[0], qn[1], qn[2], qn[3]);
         tx_gappy = p[0];
         for (int n = 0; n < PHASE_BEATS; n++) begin
            for (int c = 0; c < 3; c++) begin
               if ($urandom_range(0, 3) == 0) vn[c] = $urandom;
               else vn[c] = 16'($urandom_range(0, 4095)) - 16'd2048;
            end
            send_vec(vn[0], vn[1], vn[2], 1'b0, NO_ROT);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_rot_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_cnt == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // result side: random stalls, plus one long hold-off to back up the pipe
   initial begin
      int stall;
      int seen;
      bit rx_gappy;
      bit held;
      seen     = 0;
      held     = 1'b0;
      rx_gappy = 1'b1;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (seen % 64 == 0) rx_gappy = $urandom_range(0, 1);
         stall = rx_gappy ? $urandom_range(0, 15) : 0;
         if (!held && seen >= 200 && req_tvalid) begin
            held  = 1'b1;
            stall = 400;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         seen++;
      end
   end

   always @(posedge clock) begin
      rot_beat_type want;
      logic [15:0]  got_f [4];
      logic [15:0]  want_f [4];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rot_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h clip %b",
                     $time, rsp_tdata, rsp_tuser);
            err_cnt++;
         end else begin
            want   = expected_rot_q.pop_front();
            got_f  = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32],
                       {15'd0, rsp_tuser}};
            want_f = '{want.rx, want.ry, want.rz, {15'd0, want.clip}};
            for (int k = 0; k < 4; k++) begin
               if (got_f[k] !== want_f[k]) begin
                  $display("%0t: %s mismatch, expected %h, actual %h",
                           $time, field_name[k], want_f[k], got_f[k]);
                  err_cnt++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d beats still pending", $time, expected_rot_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
